// ===== rtl/spe_pkg.sv =====
// Shared types, constants and helpers of the spike rate pulse encoder.
`default_nettype none

package spe_pkg;

	localparam int WIN_W    = 16;
	localparam int NUM_W    = WIN_W + 2;
	localparam int DEN_W    = WIN_W + 1;
	localparam int DIV_STEPS = NUM_W;
	localparam int CNT_W    = $clog2(DIV_STEPS + 1);
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;
	localparam logic [WIN_W-1:0] WINDOW_RST = WIN_W'(256);

	localparam logic REG_WINDOW = 1'b0;
	localparam logic REG_MODE   = 1'b1;

	typedef enum logic [1:0] {
		MODE_LINEAR = 2'd0,
		MODE_FAST   = 2'd1,
		MODE_ROUND  = 2'd2,
		MODE_DIFF   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		PLAN_ZERO,
		PLAN_ONE,
		PLAN_REM,
		PLAN_INTERVAL
	} plan_t;

	typedef enum logic {
		SEL_PLAN,
		SEL_INTERVAL
	} div_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV_A,
		ST_WAIT_A,
		ST_DIV_B,
		ST_WAIT_B,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic     load_in;
		logic     eval;
		logic     div_start;
		div_sel_t div_sel;
		logic     take_quot;
		logic     take_rem;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		plan_t plan;
		logic  two_div;
		logic  div_busy;
		logic  div_done;
	} status_t;

	function automatic logic [WIN_W-1:0] nz(input logic [WIN_W-1:0] d);
		nz = (d == '0) ? WIN_W'(1) : d;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/spe_if.sv =====
// Stream channels of the encoder: input sample beats and result beats.
`default_nettype none

interface spe_in_if;
	logic                          valid;
	logic                          ready;
	logic [spe_pkg::WIN_W-1:0]     step_pos;
	logic [spe_pkg::WIN_W-1:0]     sample_value;

	modport source (output valid, output step_pos, output sample_value, input ready);
	modport sink (input valid, input step_pos, input sample_value, output ready);
endinterface

interface spe_out_if;
	logic valid;
	logic ready;
	logic pulse;

	modport source (output valid, output pulse, input ready);
	modport sink (input valid, input pulse, output ready);
endinterface

`default_nettype wire

// ===== rtl/spe_regs.sv =====
// APB configuration registers: sample window and mapping mode.
`default_nettype none

module spe_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [spe_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [spe_pkg::DATA_W-1:0]    pwdata,
	output logic      [spe_pkg::DATA_W-1:0]    prdata,
	output logic                               pready,
	output logic      [spe_pkg::WIN_W-1:0]     window,
	output spe_pkg::mode_t                     mode
);

	logic [spe_pkg::WIN_W-1:0] window_q;
	spe_pkg::mode_t            mode_q;
	logic                      wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= spe_pkg::WINDOW_RST;
			mode_q   <= spe_pkg::MODE_LINEAR;
		end else if (wr_en) begin
			if (paddr[2] == spe_pkg::REG_WINDOW) begin
				window_q <= pwdata[spe_pkg::WIN_W-1:0];
			end else begin
				mode_q <= spe_pkg::mode_t'(pwdata[1:0]);
			end
		end
	end

	always_comb begin
		if (paddr[2] == spe_pkg::REG_MODE) begin
			prdata = {{(spe_pkg::DATA_W-2){1'b0}}, mode_q};
		end else begin
			prdata = {{(spe_pkg::DATA_W-spe_pkg::WIN_W){1'b0}}, window_q};
		end
	end

	assign window = window_q;
	assign mode   = mode_q;

endmodule

`default_nettype wire

// ===== rtl/spe_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module spe_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [spe_pkg::NUM_W-1:0]     dividend,
	input  wire logic [spe_pkg::DEN_W-1:0]     divisor,
	output logic                               busy,
	output logic                               done,
	output logic      [spe_pkg::NUM_W-1:0]     quot,
	output logic      [spe_pkg::DEN_W-1:0]     rem
);

	logic [spe_pkg::CNT_W-1:0] cnt_q;
	logic                      done_q;
	logic [spe_pkg::NUM_W-1:0] quo_q;
	logic [spe_pkg::DEN_W-1:0] rem_q;
	logic [spe_pkg::DEN_W-1:0] den_q;
	logic [spe_pkg::NUM_W-1:0] trial;
	logic [spe_pkg::NUM_W-1:0] diff;
	logic                      fits;

	assign trial = {rem_q, quo_q[spe_pkg::NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == spe_pkg::CNT_W'(1));
			if (start) begin
				cnt_q <= spe_pkg::CNT_W'(spe_pkg::DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - spe_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (cnt_q != '0) begin
			// shift in next dividend bit, subtract when it fits
			rem_q <= fits ? diff[spe_pkg::DEN_W-1:0] : trial[spe_pkg::DEN_W-1:0];
			quo_q <= {quo_q[spe_pkg::NUM_W-2:0], fits};
		end
	end

	assign busy = (cnt_q != '0);
	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/spe_dp.sv =====
// Datapath: sample capture, mode decode, differential state, divider, result.
`default_nettype none

module spe_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire spe_pkg::cmd_t                 cmd,
	output spe_pkg::status_t                   status,
	input  wire logic [spe_pkg::WIN_W-1:0]     window,
	input  wire spe_pkg::mode_t                mode,
	input  wire logic [spe_pkg::WIN_W-1:0]     step_pos,
	input  wire logic [spe_pkg::WIN_W-1:0]     sample_value,
	output logic                               pulse
);

	localparam int W = spe_pkg::WIN_W;

	logic [W-1:0]               step_q;
	logic [W-1:0]               val_q;
	logic [W-1:0]               last_value_q;
	logic [W-1:0]               last_window_q;
	spe_pkg::plan_t             plan_q;
	logic                       lower_q;
	logic [spe_pkg::NUM_W-1:0]  num_q;
	logic [spe_pkg::DEN_W-1:0]  den_q;
	logic [W-1:0]               interval_q;
	logic                       pulse_q;
	logic                       out_pulse_q;

	logic [W-1:0]               upper;
	logic [W-1:0]               lv_eff;
	logic [W-1:0]               change;
	logic [W-1:0]               rate1;
	logic [W-1:0]               divisor;
	logic                       below_half;
	logic                       out_of_range;
	spe_pkg::plan_t             plan;
	logic                       lower;
	logic [spe_pkg::NUM_W-1:0]  num;
	logic [spe_pkg::DEN_W-1:0]  den;

	logic                       div_busy;
	logic                       div_done;
	logic [spe_pkg::NUM_W-1:0]  div_num;
	logic [spe_pkg::DEN_W-1:0]  div_den;
	logic [spe_pkg::NUM_W-1:0]  quot;
	logic [spe_pkg::DEN_W-1:0]  rem;

	assign upper        = window - W'(1);
	assign out_of_range = val_q >= window;
	// a new window restarts the differential history from zero
	assign lv_eff       = (last_window_q != window) ? '0 : last_value_q;
	assign change       = (val_q > lv_eff) ? val_q - lv_eff : lv_eff - val_q;
	assign rate1        = ((window - change) >> 1) + W'(1);
	assign below_half   = val_q < (upper >> 1);
	assign divisor      = below_half ? val_q : upper - val_q;

	always_comb begin
		plan  = spe_pkg::PLAN_ZERO;
		lower = 1'b1;
		num   = {2'b00, step_q};
		den   = {1'b0, spe_pkg::nz(window - val_q)};
		if (out_of_range) begin
			plan = spe_pkg::PLAN_ZERO;
		end else if (mode == spe_pkg::MODE_LINEAR) begin
			plan = spe_pkg::PLAN_REM;
		end else if (mode == spe_pkg::MODE_DIFF && change != '0) begin
			plan = spe_pkg::PLAN_REM;
			den  = {1'b0, rate1};
		end else if (val_q == '0 || val_q >= upper) begin
			plan = spe_pkg::PLAN_ONE;
		end else begin
			plan  = spe_pkg::PLAN_INTERVAL;
			lower = below_half;
			if (mode == spe_pkg::MODE_ROUND) begin
				// round half up: (2*upper + d) / (2*d)
				num = {1'b0, upper, 1'b0} + {2'b00, divisor};
				den = {spe_pkg::nz(divisor), 1'b0};
			end else begin
				num = {2'b00, upper};
				den = {1'b0, spe_pkg::nz(divisor)};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_value_q  <= '0;
			last_window_q <= '0;
		end else if (cmd.eval && !out_of_range && mode == spe_pkg::MODE_DIFF) begin
			last_value_q  <= val_q;
			last_window_q <= window;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			step_q <= step_pos;
			val_q  <= sample_value;
		end
		if (cmd.eval) begin
			plan_q  <= plan;
			lower_q <= lower;
			num_q   <= num;
			den_q   <= den;
			pulse_q <= (plan == spe_pkg::PLAN_ONE);
		end
		if (cmd.take_quot) begin
			interval_q <= spe_pkg::nz(quot[W-1:0]);
		end
		if (cmd.take_rem) begin
			pulse_q <= lower_q ? (rem == '0) : (rem != '0);
		end
		if (cmd.out_load) begin
			out_pulse_q <= pulse_q;
		end
	end

	always_comb begin
		if (cmd.div_sel == spe_pkg::SEL_INTERVAL) begin
			div_num = {2'b00, step_q};
			div_den = {1'b0, interval_q};
		end else begin
			div_num = num_q;
			div_den = den_q;
		end
	end

	spe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	assign status = spe_pkg::status_t'{
		plan:     plan,
		two_div:  (plan_q == spe_pkg::PLAN_INTERVAL),
		div_busy: div_busy,
		div_done: div_done
	};
	assign pulse = out_pulse_q;

endmodule

`default_nettype wire

// ===== rtl/spe_ctrl.sv =====
// Controller: sequences capture, decode, up to two divisions and result load.
`default_nettype none

module spe_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire spe_pkg::status_t     status,
	output spe_pkg::cmd_t             cmd
);

	spe_pkg::state_t state_q;
	spe_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			spe_pkg::ST_IDLE: begin
				if (in_valid) state_d = spe_pkg::ST_EVAL;
			end
			spe_pkg::ST_EVAL: begin
				if (status.plan == spe_pkg::PLAN_ZERO || status.plan == spe_pkg::PLAN_ONE) begin
					state_d = spe_pkg::ST_FIN;
				end else begin
					state_d = spe_pkg::ST_DIV_A;
				end
			end
			spe_pkg::ST_DIV_A: state_d = spe_pkg::ST_WAIT_A;
			spe_pkg::ST_WAIT_A: begin
				if (status.div_done) begin
					state_d = status.two_div ? spe_pkg::ST_DIV_B : spe_pkg::ST_FIN;
				end
			end
			spe_pkg::ST_DIV_B: state_d = spe_pkg::ST_WAIT_B;
			spe_pkg::ST_WAIT_B: begin
				if (status.div_done) state_d = spe_pkg::ST_FIN;
			end
			spe_pkg::ST_FIN: begin
				if (out_free) state_d = spe_pkg::ST_IDLE;
			end
			default: state_d = spe_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			spe_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			spe_pkg::ST_EVAL: cmd.eval = 1'b1;
			spe_pkg::ST_DIV_A: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = spe_pkg::SEL_PLAN;
			end
			spe_pkg::ST_WAIT_A: begin
				cmd.take_quot = status.div_done && status.two_div;
				cmd.take_rem  = status.div_done && !status.two_div;
			end
			spe_pkg::ST_DIV_B: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = spe_pkg::SEL_INTERVAL;
			end
			spe_pkg::ST_WAIT_B: cmd.take_rem = status.div_done;
			spe_pkg::ST_FIN:    cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spe_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/spike_rate_pulse_encoder.sv =====
// Top level of the spike rate pulse encoder: registers, controller, datapath.
`default_nettype none

// One sample beat gives one pulse beat. Linear and differential beats with a
// change take one division; proportional beats that need an interval take
// two divisions; out-of-window values and the proportional end cases take
// none, and all divisions run on the single shared radix-2 divider.
// A result waits in the output register while the next sample is accepted.
// Write the window and mode registers only while no beat is in flight.
module spike_rate_pulse_encoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	spe_in_if.sink                             sample,
	spe_out_if.source                          result,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [spe_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [spe_pkg::DATA_W-1:0]    pwdata,
	output logic      [spe_pkg::DATA_W-1:0]    prdata,
	output logic                               pready
);

	logic [spe_pkg::WIN_W-1:0] window;
	spe_pkg::mode_t            mode;
	spe_pkg::cmd_t             cmd;
	spe_pkg::status_t          status;
	logic                      pulse;
	logic                      in_ready;
	logic                      out_valid;

	spe_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.window  (window),
		.mode    (mode)
	);

	spe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	spe_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.window       (window),
		.mode         (mode),
		.step_pos     (sample.step_pos),
		.sample_value (sample.sample_value),
		.pulse        (pulse)
	);

	assign sample.ready = in_ready;
	assign result.valid = out_valid;
	assign result.pulse = pulse;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !status.div_busy)
		else $error("divider started while busy");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!result.valid || result.ready))
		else $error("pending result overwritten");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> !sample.ready)
		else $error("second beat taken while one is in work");

	a_done_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> !cmd.div_start)
		else $error("division done and start in the same cycle");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of the spike rate pulse encoder: table, random beats, APB settings.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASE_COUNT = 10;
	localparam int PHASE_BEATS = 105;
	localparam int ROW_COUNT = 25;
	localparam int PRINT_CAP = 30;

	// byte address is the register index times four
	localparam logic [spe_pkg::ADDR_W-1:0] ADDR_WINDOW = {spe_pkg::REG_WINDOW, 2'b00};
	localparam logic [spe_pkg::ADDR_W-1:0] ADDR_MODE   = {spe_pkg::REG_MODE, 2'b00};

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_t;

	typedef struct packed {
		spe_pkg::mode_t             mode;
		logic [spe_pkg::WIN_W-1:0]  window;
		logic [spe_pkg::WIN_W-1:0]  step;
		logic [spe_pkg::WIN_W-1:0]  value;
		logic                       known;
		logic                       pulse;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [spe_pkg::ADDR_W-1:0] paddr;
	logic [spe_pkg::DATA_W-1:0] pwdata;
	logic [spe_pkg::DATA_W-1:0] prdata;
	logic                       pready;

	spe_in_if  sample_if ();
	spe_out_if result_if ();

	spike_rate_pulse_encoder u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_if),
		.result  (result_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// encoder settings and differential history as the predictor sees them
	logic [spe_pkg::WIN_W-1:0] cfg_window;
	spe_pkg::mode_t            cfg_mode;
	logic [spe_pkg::WIN_W-1:0] diff_value;
	logic [spe_pkg::WIN_W-1:0] diff_window;

	logic             pending_pulses[$];
	logic             expected_pulse;
	idle_t            idle_mode = IDLE_NONE;
	logic             hold_request = 1'b0;
	int               error_count = 0;
	int               cycle_count = 0;
	int               beats_sent = 0;
	int               results_seen = 0;
	int               pulses_high = 0;
	int               settings_count = 0;

	stim_row_t directed_rows [ROW_COUNT] = '{
		'{spe_pkg::MODE_LINEAR, 16'd256,   16'd0,     16'd0,     1'b1, 1'b1},
		'{spe_pkg::MODE_LINEAR, 16'd256,   16'd5,     16'd255,   1'b1, 1'b1},
		'{spe_pkg::MODE_LINEAR, 16'd256,   16'd7,     16'd256,   1'b1, 1'b0},
		'{spe_pkg::MODE_LINEAR, 16'd256,   16'd65534, 16'd0,     1'b1, 1'b0},
		'{spe_pkg::MODE_LINEAR, 16'd256,   16'd10,    16'd246,   1'b0, 1'b0},
		'{spe_pkg::MODE_LINEAR, 16'd65535, 16'd65534, 16'd65534, 1'b1, 1'b1},
		'{spe_pkg::MODE_LINEAR, 16'd65535, 16'd0,     16'd65535, 1'b1, 1'b0},
		'{spe_pkg::MODE_FAST,   16'd256,   16'd9,     16'd0,     1'b1, 1'b1},
		'{spe_pkg::MODE_FAST,   16'd256,   16'd9,     16'd255,   1'b1, 1'b1},
		'{spe_pkg::MODE_FAST,   16'd256,   16'd7,     16'd254,   1'b0, 1'b0},
		'{spe_pkg::MODE_FAST,   16'd256,   16'd10,    16'd50,    1'b0, 1'b0},
		'{spe_pkg::MODE_FAST,   16'd256,   16'd123,   16'd127,   1'b0, 1'b0},
		'{spe_pkg::MODE_FAST,   16'd256,   16'd126,   16'd126,   1'b0, 1'b0},
		'{spe_pkg::MODE_ROUND,  16'd256,   16'd3,     16'd100,   1'b0, 1'b0},
		'{spe_pkg::MODE_ROUND,  16'd256,   16'd0,     16'd200,   1'b0, 1'b0},
		'{spe_pkg::MODE_ROUND,  16'd65535, 16'd65534, 16'd65533, 1'b0, 1'b0},
		'{spe_pkg::MODE_ROUND,  16'd256,   16'd1,     16'd256,   1'b1, 1'b0},
		'{spe_pkg::MODE_DIFF,   16'd256,   16'd0,     16'd100,   1'b0, 1'b0},
		'{spe_pkg::MODE_DIFF,   16'd256,   16'd4,     16'd100,   1'b0, 1'b0},
		'{spe_pkg::MODE_DIFF,   16'd256,   16'd2,     16'd0,     1'b0, 1'b0},
		'{spe_pkg::MODE_DIFF,   16'd256,   16'd1,     16'd255,   1'b0, 1'b0},
		'{spe_pkg::MODE_DIFF,   16'd256,   16'd1,     16'd300,   1'b1, 1'b0},
		'{spe_pkg::MODE_DIFF,   16'd65535, 16'd65534, 16'd65534, 1'b0, 1'b0},
		'{spe_pkg::MODE_DIFF,   16'd1,     16'd65534, 16'd0,     1'b1, 1'b1},
		'{spe_pkg::MODE_FAST,   16'd1,     16'd3,     16'd1,     1'b1, 1'b0}
	};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_pulses.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		// keep the log short when the block is badly broken
		if (error_count < PRINT_CAP)
			$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Pulse decision for one sample beat under the current settings.
	function automatic logic predict_pulse(input logic [spe_pkg::WIN_W-1:0] step,
			input logic [spe_pkg::WIN_W-1:0] value);
		int unsigned win;
		int unsigned stp;
		int unsigned val;
		int unsigned upper;
		int unsigned divisor;
		int unsigned interval;
		int unsigned change;
		int unsigned rate;
		logic        lower;
		win = cfg_window;
		stp = step;
		val = value;
		if (val >= win)
			return 1'b0;
		if (cfg_mode == spe_pkg::MODE_LINEAR)
			return (stp % (win - val)) == 0;
		if (cfg_mode == spe_pkg::MODE_DIFF) begin
			// a new window restarts the history from zero
			if (diff_window != cfg_window) begin
				diff_value = '0;
				diff_window = cfg_window;
			end
			change = (val > diff_value) ? val - diff_value : diff_value - val;
			diff_value = value;
			if (change != 0) begin
				rate = (win > change) ? (win - change) / 2 : 0;
				return rate == 0 || (stp % (rate + 1)) == 0;
			end
		end
		upper = win - 1;
		if (val == 0 || val >= upper)
			return 1'b1;
		lower = val < upper / 2;
		divisor = lower ? val : upper - val;
		if (cfg_mode == spe_pkg::MODE_ROUND)
			interval = (upper * 2 + divisor) / (divisor * 2);
		else
			interval = upper / divisor;
		if (interval == 0)
			interval = 1;
		return lower ? (stp % interval) == 0 : (stp % interval) != 0;
	endfunction

	// Entered and left just after a falling edge.
	task automatic apb_access(input logic write, input logic [spe_pkg::ADDR_W-1:0] addr,
			input logic [spe_pkg::DATA_W-1:0] wdata,
			output logic [spe_pkg::DATA_W-1:0] rdata);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = write;
		paddr = addr;
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_encoder(input logic [spe_pkg::WIN_W-1:0] window,
			input spe_pkg::mode_t mode);
		logic [spe_pkg::DATA_W-1:0] rdata;
		sample_if.valid = 1'b0;
		while (pending_pulses.size() != 0)
			@(negedge clk);
		apb_access(1'b1, ADDR_WINDOW, spe_pkg::DATA_W'(window), rdata);
		apb_access(1'b1, ADDR_MODE, spe_pkg::DATA_W'(mode), rdata);
		apb_access(1'b0, ADDR_WINDOW, '0, rdata);
		if (rdata[spe_pkg::WIN_W-1:0] !== window)
			report_mismatch($sformatf("window reads %0d, wrote %0d",
				rdata[spe_pkg::WIN_W-1:0], window));
		apb_access(1'b0, ADDR_MODE, '0, rdata);
		if (rdata[1:0] !== mode)
			report_mismatch($sformatf("mode reads %0d, wrote %0d", rdata[1:0], mode));
		cfg_window = window;
		cfg_mode = mode;
		settings_count++;
	endtask

	// Offer one beat; valid stays high on return so back-to-back beats need no drop.
	task automatic send_sample(input logic [spe_pkg::WIN_W-1:0] step,
			input logic [spe_pkg::WIN_W-1:0] value,
			input logic known, input logic known_pulse);
		logic predicted;
		while ((idle_mode == IDLE_SEND && $urandom_range(99) < 52) ||
				(idle_mode == IDLE_BOTH && $urandom_range(99) < 34)) begin
			sample_if.valid = 1'b0;
			@(negedge clk);
		end
		sample_if.valid = 1'b1;
		sample_if.step_pos = step;
		sample_if.sample_value = value;
		do @(posedge clk); while (!sample_if.ready);
		predicted = predict_pulse(step, value);
		pending_pulses.push_back(known ? known_pulse : predicted);
		beats_sent++;
		@(negedge clk);
	endtask

	always begin
		@(negedge clk);
		if (hold_request) begin
			result_if.ready = 1'b0;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_request = 1'b0;
		end else begin
			case (idle_mode)
				IDLE_RECV: result_if.ready = $urandom_range(99) >= 52;
				IDLE_BOTH: result_if.ready = $urandom_range(99) >= 34;
				default:   result_if.ready = 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_pulses.size() == 0) begin
				report_mismatch($sformatf("result beat %0d with no sample pending",
					results_seen));
			end else begin
				expected_pulse = pending_pulses.pop_front();
				if (result_if.pulse !== expected_pulse)
					report_mismatch($sformatf("result beat %0d: pulse %b, expected %b",
						results_seen, result_if.pulse, expected_pulse));
			end
			if (result_if.pulse === 1'b1)
				pulses_high++;
			results_seen++;
		end
	end

	initial begin
		logic [spe_pkg::WIN_W-1:0] phase_windows [PHASE_COUNT];
		spe_pkg::mode_t            phase_modes [PHASE_COUNT];
		logic [spe_pkg::WIN_W-1:0] window;
		logic [spe_pkg::WIN_W-1:0] step;
		logic [spe_pkg::WIN_W-1:0] value;
		logic [spe_pkg::WIN_W-1:0] prev_value;
		spe_pkg::mode_t            mode;
		int               win;
		int               val;
		int               pick;
		int               span;

		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_if.valid = 1'b0;
		sample_if.step_pos = '0;
		sample_if.sample_value = '0;
		result_if.ready = 1'b0;
		cfg_window = spe_pkg::WINDOW_RST;
		cfg_mode = spe_pkg::MODE_LINEAR;
		diff_value = '0;
		diff_window = '0;
		prev_value = '0;
		phase_windows = '{16'd65535, 16'd256, 16'd1, 16'd2, 16'd0,
			16'd65535, 16'd0, 16'd3, 16'd0, 16'd0};
		phase_modes = '{spe_pkg::MODE_LINEAR, spe_pkg::MODE_FAST, spe_pkg::MODE_ROUND,
			spe_pkg::MODE_DIFF, spe_pkg::MODE_DIFF, spe_pkg::MODE_ROUND,
			spe_pkg::MODE_FAST, spe_pkg::MODE_LINEAR, spe_pkg::MODE_DIFF,
			spe_pkg::MODE_LINEAR};

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].window != cfg_window || directed_rows[i].mode != cfg_mode)
				set_encoder(directed_rows[i].window, directed_rows[i].mode);
			send_sample(directed_rows[i].step, directed_rows[i].value,
				directed_rows[i].known, directed_rows[i].pulse);
		end

		for (int p = 0; p < PHASE_COUNT; p++) begin
			window = phase_windows[p];
			mode = phase_modes[p];
			// zero in the phase list means draw a window, mostly a small one
			if (window == 0)
				window = ($urandom_range(99) < 70) ?
					spe_pkg::WIN_W'($urandom_range(600, 4)) :
					spe_pkg::WIN_W'($urandom_range(65535, 1));
			if (p == PHASE_COUNT - 1)
				mode = spe_pkg::mode_t'($urandom_range(3));
			set_encoder(window, mode);
			idle_mode = idle_t'(p % 4);
			win = window;
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (p == 0 && n == 20)
					hold_request = 1'b1;
				if (p == 0 && n == 60) begin
					sample_if.valid = 1'b0;
					while (pending_pulses.size() != 0)
						@(negedge clk);
				end
				pick = $urandom_range(99);
				if (pick < 10)
					val = win + $urandom_range(65535 - win);
				else if (pick < 18)
					val = 0;
				else if (pick < 36) begin
					case ($urandom_range(6))
						0: val = win - 1;
						1: val = win - 2;
						2: val = (win - 1) / 2;
						3: val = (win - 1) / 2 - 1;
						4: val = (win - 1) / 2 + 1;
						5: val = 1;
						default: val = win - 3;
					endcase
				end else if (mode == spe_pkg::MODE_DIFF && pick < 52)
					val = prev_value;
				else if (mode == spe_pkg::MODE_DIFF && pick < 64)
					val = int'(prev_value) + $urandom_range(8) - 4;
				else
					val = $urandom_range(win - 1);
				value = spe_pkg::WIN_W'(val);
				pick = $urandom_range(99);
				if (pick < 15)
					step = '0;
				else if (mode == spe_pkg::MODE_LINEAR && pick < 35 && value < window) begin
					// land on a multiple of the linear period
					span = win - int'(value);
					step = spe_pkg::WIN_W'(span * $urandom_range(65534 / span));
				end else if (pick < 60)
					step = spe_pkg::WIN_W'($urandom_range(win - 1));
				else
					step = spe_pkg::WIN_W'($urandom_range(65534));
				send_sample(step, value, 1'b0, 1'b0);
				prev_value = value;
			end
		end

		sample_if.valid = 1'b0;
		idle_mode = IDLE_NONE;
		while (pending_pulses.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d sample beats under %0d window/mode settings in four idling patterns;",
			beats_sent, settings_count);
		$display("checked %0d result beats, %0d of them pulsed, %0d mismatches.",
			results_seen, pulses_high, error_count);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/spe_pkg.sv
rtl/spe_if.sv
rtl/spe_regs.sv
rtl/spe_div.sv
rtl/spe_dp.sv
rtl/spe_ctrl.sv
rtl/spike_rate_pulse_encoder.sv
tb/tb_top.sv
